// File: design/bb3_pkg.sv
// Package for the 3x3 box blur: payload structs, controller/datapath command types
// and shared constants. Depends on nothing; every block file refers to it by scoped names.
package bb3_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 4096;

	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_DATA_W   = 13;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	// Rounded quotient numerator 2*sum+n is at most 2*9*255+9 and fits in 13 bits.
	localparam int NUM_W     = 13;
	localparam int SUM_W     = 12;
	localparam int DEN_W     = 5;
	localparam int DIV_STEPS = NUM_W;

	typedef struct packed {
		logic       action;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       last_of_run;
		logic       end_of_frame;
	} out_item_t;

	typedef struct packed {
		logic       in_take;
		logic       rd_en;
		logic       win_shift;
		logic       flush_load;
		logic [1:0] flush_col;
		logic       acc_start;
		logic [2:0] rows;
		logic [2:0] cols;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
	} dp_stat_t;

endpackage

// File: design/bb3_datapath.sv
// Datapath of the 3x3 box blur: two line stores, the 3x3 window, the masked sum
// and one bit-serial divider per channel on a shared step count. Uses bb3_pkg.
module bb3_datapath #(
	parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bb3_pkg::dp_cmd_t  cmd,
	input  logic [AW-1:0]     addr,
	input  bb3_pkg::in_item_t pix,
	output bb3_pkg::dp_stat_t stat,
	output logic [7:0]        red,
	output logic [7:0]        green,
	output logic [7:0]        blue
);

	logic [23:0] upper_mem [MAX_WIDTH];
	logic [23:0] lower_mem [MAX_WIDTH];
	logic [23:0] rd_upper_q;
	logic [23:0] rd_lower_q;
	logic [23:0] px_q;
	logic [23:0] win_q [3][3];

	logic [bb3_pkg::SUM_W-1:0] sum [3];
	logic [3:0]                cnt;
	logic [bb3_pkg::NUM_W-1:0] num_init [3];
	logic [bb3_pkg::DEN_W-1:0] den_init;

	logic [bb3_pkg::NUM_W-1:0] num_q [3];
	logic [bb3_pkg::DEN_W-1:0] rem_q [3];
	logic [bb3_pkg::DEN_W-1:0] den_q;
	logic [3:0]                step_q;

	logic [bb3_pkg::DEN_W:0]   trial [3];
	logic                      fits [3];
	logic [bb3_pkg::DEN_W-1:0] rem_next [3];

	always_ff @(posedge clk) begin
		if (cmd.in_take) begin
			px_q <= {pix.red_in, pix.green_in, pix.blue_in};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_upper_q <= upper_mem[addr];
		end
		if (cmd.win_shift) begin
			upper_mem[addr] <= rd_lower_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_lower_q <= lower_mem[addr];
		end
		if (cmd.win_shift) begin
			lower_mem[addr] <= px_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.win_shift) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= rd_upper_q;
			win_q[1][2] <= rd_lower_q;
			win_q[2][2] <= px_q;
		end else if (cmd.flush_load) begin
			win_q[0][cmd.flush_col] <= rd_upper_q;
			win_q[1][cmd.flush_col] <= rd_lower_q;
		end
	end

	always_comb begin
		cnt = '0;
		for (int ch = 0; ch < 3; ch++) begin
			sum[ch] = '0;
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (cmd.rows[i] && cmd.cols[j]) begin
					cnt = cnt + 4'd1;
					for (int ch = 0; ch < 3; ch++) begin
						sum[ch] = sum[ch] + bb3_pkg::SUM_W'(win_q[i][j][8*(2-ch) +: 8]);
					end
				end
			end
		end
		if (cnt == 4'd0) begin
			cnt = 4'd1;
		end
		den_init = {cnt, 1'b0};
		for (int ch = 0; ch < 3; ch++) begin
			num_init[ch] = {sum[ch], 1'b0} + bb3_pkg::NUM_W'(cnt);
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			trial[ch]    = {rem_q[ch], num_q[ch][bb3_pkg::NUM_W-1]};
			fits[ch]     = trial[ch] >= {1'b0, den_q};
			rem_next[ch] = fits[ch] ? bb3_pkg::DEN_W'(trial[ch] - {1'b0, den_q})
			                        : trial[ch][bb3_pkg::DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.acc_start) begin
			step_q <= 4'(bb3_pkg::DIV_STEPS);
		end else if (step_q != 4'd0) begin
			step_q <= step_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_start) begin
			den_q <= den_init;
			for (int ch = 0; ch < 3; ch++) begin
				num_q[ch] <= num_init[ch];
				rem_q[ch] <= '0;
			end
		end else if (step_q != 4'd0) begin
			for (int ch = 0; ch < 3; ch++) begin
				num_q[ch] <= {num_q[ch][bb3_pkg::NUM_W-2:0], fits[ch]};
				rem_q[ch] <= rem_next[ch];
			end
		end
	end

	assign stat.div_done = (step_q == 4'd0);
	assign red   = num_q[0][7:0];
	assign green = num_q[1][7:0];
	assign blue  = num_q[2][7:0];

endmodule

// File: design/bb3_ctrl.sv
// Controller of the 3x3 box blur: configuration registers, frame positions and the
// sequencing state machine that commands the datapath. Uses bb3_pkg.
module bb3_ctrl #(
	parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF,
	localparam int AW = $clog2(MAX_WIDTH),
	localparam int CW = $clog2(MAX_WIDTH + 1),
	localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            pix_valid,
	input  logic                            action,
	output logic                            pix_stall,
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic                            last_of_run,
	output logic                            end_of_frame,
	output bb3_pkg::dp_cmd_t                cmd,
	output logic [AW-1:0]                   addr,
	input  bb3_pkg::dp_stat_t               stat
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PWIN,
		S_FRD,
		S_SUM,
		S_DIV,
		S_OUT
	} state_t;

	state_t state_q;

	logic [bb3_pkg::WIDTH_REG_W-1:0]  width_q;
	logic [bb3_pkg::HEIGHT_REG_W-1:0] height_q;
	logic [CW-1:0] w_eff;
	logic [HW-1:0] h_eff;

	logic [AW-1:0] col_q;
	logic [HW-1:0] row_q;
	logic [AW-1:0] flush_q;
	logic          draining_q;
	logic [1:0]    k_q;
	logic [2:0]    rows_q;
	logic [2:0]    cols_q;
	logic          last_q;
	logic          eof_q;
	logic          pend_q;
	logic          flush_item_q;

	logic accept;
	logic last_col;
	logic last_row;
	logic col_ge1;
	logic col_ge2;
	logic row_ge1;
	logic row_ge2;
	logic f_ge1;
	logic f_more;
	logic [2:0] cols_second;

	always_comb begin
		if (width_q == '0) begin
			w_eff = CW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(height_q);
		end
	end

	assign pix_stall = (state_q != S_IDLE) || cfg_we;
	assign accept    = pix_valid && !pix_stall;
	assign res_valid = (state_q == S_OUT);
	assign last_of_run  = last_q;
	assign end_of_frame = eof_q;

	assign last_col = (32'(col_q) + 32'd1) >= 32'(w_eff);
	assign last_row = (32'(row_q) + 32'd1) >= 32'(h_eff);
	assign col_ge1  = (32'(col_q) >= 32'd1);
	assign col_ge2  = (32'(col_q) >= 32'd2);
	assign row_ge1  = (32'(row_q) >= 32'd1);
	assign row_ge2  = (32'(row_q) >= 32'd2);
	assign f_ge1    = (32'(flush_q) >= 32'd1);
	assign f_more   = (32'(flush_q) + 32'd1) < 32'(w_eff);
	assign cols_second = col_ge1 ? 3'b110 : 3'b100;

	always_comb begin
		if (state_q == S_FRD) begin
			addr = flush_q + AW'(k_q) - AW'(1);
		end else begin
			addr = col_q;
		end
		cmd.in_take    = accept;
		cmd.rd_en      = (accept && (action == bb3_pkg::ACT_PIXEL) && !draining_q)
		              || ((state_q == S_FRD) && (k_q != 2'd3));
		cmd.win_shift  = (state_q == S_PWIN);
		cmd.flush_load = (state_q == S_FRD) && (k_q != 2'd0);
		cmd.flush_col  = k_q - 2'd1;
		cmd.acc_start  = (state_q == S_SUM);
		cmd.rows       = rows_q;
		cmd.cols       = cols_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			width_q      <= bb3_pkg::WIDTH_RESET;
			height_q     <= bb3_pkg::HEIGHT_RESET;
			col_q        <= '0;
			row_q        <= '0;
			flush_q      <= '0;
			draining_q   <= 1'b0;
			k_q          <= '0;
			rows_q       <= '0;
			cols_q       <= '0;
			last_q       <= 1'b0;
			eof_q        <= 1'b0;
			pend_q       <= 1'b0;
			flush_item_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cfg_we) begin
						case (cfg_index)
							bb3_pkg::REG_IMAGE_WIDTH: begin
								width_q <= cfg_data[bb3_pkg::WIDTH_REG_W-1:0];
							end
							bb3_pkg::REG_IMAGE_HEIGHT: begin
								height_q <= cfg_data;
							end
							default: begin
							end
						endcase
						col_q      <= '0;
						row_q      <= '0;
						flush_q    <= '0;
						draining_q <= 1'b0;
					end else if (accept) begin
						if (action == bb3_pkg::ACT_FLUSH && draining_q) begin
							k_q          <= '0;
							flush_item_q <= 1'b1;
							state_q      <= S_FRD;
						end else if (action == bb3_pkg::ACT_PIXEL && !draining_q) begin
							flush_item_q <= 1'b0;
							state_q      <= S_PWIN;
						end
					end
				end
				S_PWIN: begin
					rows_q <= row_ge2 ? 3'b111 : 3'b110;
					eof_q  <= 1'b0;
					if (row_ge1 && col_ge1) begin
						cols_q  <= col_ge2 ? 3'b111 : 3'b110;
						last_q  <= !last_col;
						pend_q  <= last_col;
						state_q <= S_SUM;
					end else if (row_ge1 && last_col) begin
						cols_q  <= cols_second;
						last_q  <= 1'b1;
						pend_q  <= 1'b0;
						state_q <= S_SUM;
					end else begin
						if (last_col) begin
							col_q <= '0;
							if (last_row) begin
								row_q      <= '0;
								flush_q    <= '0;
								draining_q <= 1'b1;
							end else begin
								row_q <= row_q + HW'(1);
							end
						end else begin
							col_q <= col_q + AW'(1);
						end
						state_q <= S_IDLE;
					end
				end
				S_FRD: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						rows_q  <= (32'(h_eff) >= 32'd2) ? 3'b011 : 3'b010;
						cols_q  <= {f_more, 1'b1, f_ge1};
						last_q  <= 1'b1;
						eof_q   <= !f_more;
						pend_q  <= 1'b0;
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (stat.div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!res_stall) begin
						if (pend_q) begin
							cols_q  <= cols_second;
							last_q  <= 1'b1;
							pend_q  <= 1'b0;
							state_q <= S_SUM;
						end else begin
							if (flush_item_q) begin
								if (eof_q) begin
									col_q      <= '0;
									row_q      <= '0;
									flush_q    <= '0;
									draining_q <= 1'b0;
								end else begin
									flush_q <= flush_q + AW'(1);
								end
							end else if (last_col) begin
								col_q <= '0;
								if (last_row) begin
									row_q      <= '0;
									flush_q    <= '0;
									draining_q <= 1'b1;
								end else begin
									row_q <= row_q + HW'(1);
								end
							end else begin
								col_q <= col_q + AW'(1);
							end
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: design/box_blur_3x3_edge_normalized.sv
// Top level of the 3x3 box blur with edge-normalized mean; joins bb3_ctrl and
// bb3_datapath. Uses bb3_pkg for payload and command types.
//
//   port group   dir  handshake             payload
//   pix          in   pix_valid/pix_stall   bb3_pkg::in_item_t
//   res          out  res_valid/res_stall   bb3_pkg::out_item_t
//   cfg          in   cfg_we                cfg_index, cfg_data
//
// A pixel item produces no result, one result or two; a flush item produces one;
// stalls on res lengthen an item. Each result waits on the 13-step bit-serial
// dividers, one per channel, which share one denominator and step counter.
// Reset restores 640x480 and starts a new frame; the line stores are not cleared.
// One item is worked at a time, and pix_stall stays high until the item is done.
module box_blur_3x3_edge_normalized #(
	parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            pix_valid,
	output logic                            pix_stall,
	input  bb3_pkg::in_item_t               pix,
	output logic                            res_valid,
	input  logic                            res_stall,
	output bb3_pkg::out_item_t              res
);

	localparam int AW = $clog2(MAX_WIDTH);

	bb3_pkg::dp_cmd_t  cmd;
	bb3_pkg::dp_stat_t stat;
	logic [AW-1:0]     addr;
	logic [7:0]        red;
	logic [7:0]        green;
	logic [7:0]        blue;
	logic              last_of_run;
	logic              end_of_frame;

	bb3_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pix_valid    (pix_valid),
		.action       (pix.action),
		.pix_stall    (pix_stall),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.last_of_run  (last_of_run),
		.end_of_frame (end_of_frame),
		.cmd          (cmd),
		.addr         (addr),
		.stat         (stat)
	);

	bb3_datapath #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.addr   (addr),
		.pix    (pix),
		.stat   (stat),
		.red    (red),
		.green  (green),
		.blue   (blue)
	);

	assign res.red_out      = red;
	assign res.green_out    = green;
	assign res.blue_out     = blue;
	assign res.last_of_run  = last_of_run;
	assign res.end_of_frame = end_of_frame;

endmodule
